### src/fba_pkg.sv
// Shared types, codes and default sizes for the frame bitmap allocator.
package fba_pkg;

  // Default sizing of the bitmap.
  localparam int unsigned MaxFramesDef = 4096;
  localparam int unsigned WordBitsDef  = 32;

  // Fixed field widths of the request and result transactions.
  localparam int unsigned FrameW  = 12;
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 13;

  // Value of the frame count register after reset.
  localparam logic [CountW-1:0] CountReset = 13'h1000;

  typedef enum logic [OpcodeW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_NOP     = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

endpackage

### src/frame_bitmap_allocator_unit.sv
// Top level of the frame bitmap allocator: control sequencer around the bitmap store.
//
// The block keeps one bit per physical page frame in a word-wide synchronous memory.
// A request transaction is taken at a rising edge with start high and busy low; it
// carries an opcode (allocate, free or test), the page entry's current frame, a frame
// to test and the kernel and writable flags. Exactly one result transaction follows:
// result_valid_o is high for a single cycle with the status, the frame now held by the
// entry, the entry bits and the test answer. The receiver cannot stall the block, so
// results are never held back.
// The request is registered into the execute state, which loads the result registers and
// raises the result strobe. Busy falls together with the rising strobe, so a new request
// is taken no earlier than the edge at which the last result is taken. An allocation
// stays in the execute state while it steps over completely used words: a word pointer
// that is never ahead of the first word with a free frame sets this, and the single read
// port of the bitmap memory visits one word per cycle.
// The frame count register is written over its own valid/ready channel, which is always
// ready; it should only be written while the block is idle.
// After reset the block runs a clearing pass that writes every bitmap word to zero, one
// word per cycle; busy stays high until it ends.
module frame_bitmap_allocator_unit #(
  parameter int unsigned MAX_FRAMES = fba_pkg::MaxFramesDef,
  // Must be a power of two.
  parameter int unsigned WORD_BITS  = fba_pkg::WordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [fba_pkg::OpcodeW-1:0]  opcode_i,
  input  logic [fba_pkg::FrameW-1:0]   existing_frame_i,
  input  logic [fba_pkg::FrameW-1:0]   query_frame_i,
  input  logic                         is_kernel_i,
  input  logic                         is_writeable_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fba_pkg::CountW-1:0]   cfg_frames_in_use_i,
  output logic                         result_valid_o,
  output logic [fba_pkg::StatusW-1:0]  status_o,
  output logic [fba_pkg::FrameW-1:0]   result_frame_o,
  output logic                         present_bit_o,
  output logic                         rw_bit_o,
  output logic                         user_bit_o,
  output logic                         frame_used_o
);

  localparam int unsigned NWords = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AddrW  = (NWords > 1) ? $clog2(NWords) : 1;
  // The hint pointer may point one past the last word.
  localparam int unsigned HintW  = $clog2(NWords + 1);
  localparam int unsigned BitW   = $clog2(WORD_BITS);
  localparam int unsigned Span   = NWords * WORD_BITS;
  localparam int unsigned SpanW  = $clog2(Span + 1);
  // Frame arithmetic is done at a width that holds the count register and the bitmap span.
  localparam int unsigned CalcW  = (SpanW > fba_pkg::CountW) ? SpanW : fba_pkg::CountW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  localparam logic [CalcW-1:0] MaxFramesC = CalcW'(MAX_FRAMES);

  logic [1:0]                  state_q, state_d;
  logic [AddrW-1:0]            clr_q, clr_d;
  logic [HintW-1:0]            hint_q, hint_d;
  logic [fba_pkg::CountW-1:0]  count_q;

  // Latched request.
  fba_pkg::opcode_e            op_q, op_d;
  logic [fba_pkg::FrameW-1:0]  held_q, held_d;
  logic [fba_pkg::FrameW-1:0]  query_q, query_d;
  logic                        kern_q, kern_d;
  logic                        wr_q, wr_d;

  // Result registers.
  logic                        res_valid_q, res_valid_d;
  fba_pkg::status_e            status_q, status_d;
  logic [fba_pkg::FrameW-1:0]  frame_q, frame_d;
  logic                        present_q, present_d;
  logic                        rw_q, rw_d;
  logic                        user_q, user_d;
  logic                        used_q, used_d;

  // Memory port.
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [WORD_BITS-1:0]        mem_wdata;
  logic [AddrW-1:0]            mem_raddr;
  logic [WORD_BITS-1:0]        mem_rdata;

  logic                        word_full;
  logic [BitW-1:0]             zero_idx;

  logic [CalcW-1:0]            count_c;
  logic [CalcW-1:0]            limit;
  logic [CalcW-1:0]            hint_base;
  logic [CalcW-1:0]            found;
  logic [CalcW-1:0]            held_c;
  logic [CalcW-1:0]            query_c;
  logic [CalcW-1:0]            held_in_c;
  logic [CalcW-1:0]            query_in_c;
  logic [WORD_BITS-1:0]        set_word;
  logic [WORD_BITS-1:0]        held_mask;
  logic [HintW-1:0]            held_word_h;
  logic [HintW-1:0]            hint_inc;
  logic                        accept;

  fba_bitmap_mem #(
    .Depth (NWords),
    .Width (WORD_BITS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fba_first_zero #(
    .Width (WORD_BITS),
    .IdxW  (BitW)
  ) u_first_zero (
    .word_i (mem_rdata),
    .full_o (word_full),
    .idx_o  (zero_idx)
  );

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // The search stops at the smaller of the programmed count and MAX_FRAMES.
  assign count_c    = CalcW'(count_q);
  assign limit      = (count_c > MaxFramesC) ? MaxFramesC : count_c;
  assign hint_base  = CalcW'(hint_q) << BitW;
  assign found      = hint_base | CalcW'(zero_idx);
  assign hint_inc   = HintW'(hint_q + 1'b1);
  assign held_c     = CalcW'(held_q);
  assign query_c    = CalcW'(query_q);
  assign held_in_c  = CalcW'(existing_frame_i);
  assign query_in_c = CalcW'(query_frame_i);
  assign set_word   = mem_rdata | (WORD_BITS'(1) << zero_idx);
  assign held_mask  = WORD_BITS'(1) << held_q[BitW-1:0];
  assign held_word_h = HintW'(held_c >> BitW);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    hint_d      = hint_q;
    op_d        = op_q;
    held_d      = held_q;
    query_d     = query_q;
    kern_d      = kern_q;
    wr_d        = wr_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    frame_d     = frame_q;
    present_d   = present_q;
    rw_d        = rw_q;
    user_d      = user_q;
    used_d      = used_q;
    mem_we      = 1'b0;
    mem_waddr   = AddrW'(hint_q);
    mem_wdata   = set_word;
    mem_raddr   = AddrW'(hint_q);

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = AddrW'(clr_q + 1'b1);
        if (clr_q == AddrW'(NWords - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        // Issue the read for the incoming request so that the word is ready next cycle.
        case (fba_pkg::opcode_e'(opcode_i))
          fba_pkg::OP_FREE: mem_raddr = AddrW'(held_in_c >> BitW);
          fba_pkg::OP_TEST: mem_raddr = AddrW'(query_in_c >> BitW);
          default:          mem_raddr = AddrW'(hint_q);
        endcase
        if (accept) begin
          op_d    = fba_pkg::opcode_e'(opcode_i);
          held_d  = existing_frame_i;
          query_d = query_frame_i;
          kern_d  = is_kernel_i;
          wr_d    = is_writeable_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        // Most outcomes finish here; only a scan past a used word stays.
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        status_d    = fba_pkg::ST_NOP;
        frame_d     = held_q;
        present_d   = 1'b0;
        rw_d        = 1'b0;
        user_d      = 1'b0;
        used_d      = 1'b0;
        case (op_q)
          fba_pkg::OP_ALLOC: begin
            if (held_q != '0) begin
              status_d = fba_pkg::ST_NOP;
            end else if (hint_base >= limit) begin
              status_d = fba_pkg::ST_NO_FREE;
              frame_d  = '0;
            end else if (word_full) begin
              // Every word below the hint is used, so stepping on keeps that true.
              res_valid_d = 1'b0;
              state_d     = S_EXEC;
              hint_d      = hint_inc;
              mem_raddr   = AddrW'(hint_inc);
            end else if (found >= limit) begin
              status_d = fba_pkg::ST_NO_FREE;
              frame_d  = '0;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AddrW'(hint_q);
              mem_wdata = set_word;
              if (&set_word) begin
                hint_d = hint_inc;
              end
              status_d  = fba_pkg::ST_DONE;
              frame_d   = found[fba_pkg::FrameW-1:0];
              present_d = 1'b1;
              rw_d      = wr_q;
              user_d    = ~kern_q;
            end
          end
          fba_pkg::OP_FREE: begin
            frame_d = '0;
            if (held_q != '0) begin
              status_d = fba_pkg::ST_DONE;
              if (held_c < MaxFramesC) begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(held_c >> BitW);
                mem_wdata = mem_rdata & ~held_mask;
                if (held_word_h < hint_q) begin
                  hint_d = held_word_h;
                end
              end
            end
          end
          fba_pkg::OP_TEST: begin
            status_d = fba_pkg::ST_DONE;
            used_d   = (query_c < MaxFramesC) && mem_rdata[query_q[BitW-1:0]];
          end
          default: begin
            status_d = fba_pkg::ST_NOP;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      count_q     <= fba_pkg::CountReset;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_frames_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    held_q    <= held_d;
    query_q   <= query_d;
    kern_q    <= kern_d;
    wr_q      <= wr_d;
    status_q  <= status_d;
    frame_q   <= frame_d;
    present_q <= present_d;
    rw_q      <= rw_d;
    user_q    <= user_d;
    used_q    <= used_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign result_frame_o = frame_q;
  assign present_bit_o  = present_q;
  assign rw_bit_o       = rw_q;
  assign user_bit_o     = user_q;
  assign frame_used_o   = used_q;

  // A result is only shown once the sequencer has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  // An accepted request occupies the block in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !result_valid_o))
    else $error("block not busy after a request");

  // The bitmap is never written while idle, so reads issued there see settled data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE))
    else $error("bitmap write while idle");

  // The hint never runs past one beyond the last word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= HintW'(NWords))
    else $error("hint pointer out of range");

  // Entry bits are only handed out with a completed allocation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && present_bit_o) |-> (status_o == fba_pkg::ST_DONE && !frame_used_o))
    else $error("entry bits without an allocation");

endmodule

### src/fba_bitmap_mem.sv
// Bitmap word store: one write port and one registered read port.
module fba_bitmap_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/fba_first_zero.sv
// Priority encoder that finds the lowest clear bit of a bitmap word.
module fba_first_zero #(
  parameter int unsigned Width = 32,
  parameter int unsigned IdxW  = 5
) (
  input  logic [Width-1:0] word_i,
  output logic             full_o,
  output logic [IdxW-1:0]  idx_o
);

  always_comb begin
    idx_o = '0;
    // Walk from the top so that the lowest clear bit wins.
    for (int i = Width - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        idx_o = IdxW'(i);
      end
    end
  end

  assign full_o = &word_i;

endmodule

### tb/fba_tb_pkg.sv
// Transaction types and the scoreboard class for the frame bitmap allocator testbench.
package fba_tb_pkg;
  import fba_pkg::*;

  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [FrameW-1:0]  existing;
    logic [FrameW-1:0]  query;
    logic               kernel;
    logic               writeable;
  } frame_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  frame;
    logic               present;
    logic               rw;
    logic               user;
    logic               used;
  } frame_reply_t;

  class frame_map_model;
    bit [MaxFramesDef-1:0] used_map;
    logic [CountW-1:0]     frame_limit;
    frame_reply_t          pending_replies[$];
    int unsigned           mismatches;

    function new();
      used_map    = '0;
      frame_limit = CountReset;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [CountW-1:0] value);
      frame_limit = value;
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction

    // Works out the reply to an accepted request and updates the frame map.
    function void note_request(frame_req_t req);
      frame_reply_t exp;
      int unsigned  lim;
      int unsigned  idx;
      exp         = '0;
      exp.status  = ST_NOP;
      exp.frame   = req.existing;
      case (req.opcode)
        OP_ALLOC: begin
          if (req.existing == '0) begin
            lim = (frame_limit > MaxFramesDef) ? MaxFramesDef : int'(frame_limit);
            idx = 0;
            while (idx < lim && used_map[idx]) idx++;
            if (idx < lim) begin
              used_map[idx] = 1'b1;
              exp.status    = ST_DONE;
              exp.frame     = FrameW'(idx);
              exp.present   = 1'b1;
              exp.rw        = req.writeable;
              exp.user      = ~req.kernel;
            end else begin
              exp.status = ST_NO_FREE;
              exp.frame  = '0;
            end
          end
        end
        OP_FREE: begin
          if (req.existing != '0) begin
            used_map[req.existing] = 1'b0;
            exp.status             = ST_DONE;
          end
          exp.frame = '0;
        end
        OP_TEST: begin
          exp.status = ST_DONE;
          exp.used   = used_map[req.query];
        end
        default: begin
        end
      endcase
      pending_replies.push_back(exp);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(frame_reply_t got);
      frame_reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("reply seen with no request outstanding");
        mismatches++;
        return;
      end
      exp = pending_replies.pop_front();
      compare_field("status", 16'(exp.status), 16'(got.status));
      compare_field("result_frame", 16'(exp.frame), 16'(got.frame));
      compare_field("present_bit", 16'(exp.present), 16'(got.present));
      compare_field("rw_bit", 16'(exp.rw), 16'(got.rw));
      compare_field("user_bit", 16'(exp.user), 16'(got.user));
      compare_field("frame_used", 16'(exp.used), 16'(got.used));
    endfunction
  endclass

endpackage

### tb/frame_bitmap_allocator_unit_test.sv
// Self-checking testbench for the frame bitmap allocator top level.
module frame_bitmap_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fba_pkg::*;
  import fba_tb_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OpcodeW-1:0] opcode_i;
  logic [FrameW-1:0]  existing_frame_i;
  logic [FrameW-1:0]  query_frame_i;
  logic               is_kernel_i;
  logic               is_writeable_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CountW-1:0]  cfg_frames_in_use_i;
  logic               result_valid_o;
  logic [StatusW-1:0] status_o;
  logic [FrameW-1:0]  result_frame_o;
  logic               present_bit_o;
  logic               rw_bit_o;
  logic               user_bit_o;
  logic               frame_used_o;

  // The scoreboard keeps its own copy of the frame map and of the frame count register.
  frame_map_model frame_map = new();

  // Frame counts visited by the random phases; the last entry is chosen at run time.
  int unsigned phase_limits [10] = '{4096, 1, 40, 8191, 100, 0, 64, 4095, 32, 0};

  frame_bitmap_allocator_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .opcode_i            (opcode_i),
    .existing_frame_i    (existing_frame_i),
    .query_frame_i       (query_frame_i),
    .is_kernel_i         (is_kernel_i),
    .is_writeable_i      (is_writeable_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_frames_in_use_i (cfg_frames_in_use_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .result_frame_o      (result_frame_o),
    .present_bit_o       (present_bit_o),
    .rw_bit_o            (rw_bit_o),
    .user_bit_o          (user_bit_o),
    .frame_used_o        (frame_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Everything is sampled at the rising edge, where the values seen are those that
  // the edge itself registers. A reply is checked before the request of the same edge
  // is noted; the two can never belong to the same transaction anyway, since a reply
  // is always sampled at a later edge than its request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        frame_map.check_reply('{status_o, result_frame_o, present_bit_o, rw_bit_o,
                                user_bit_o, frame_used_o});
      end
      if (start && !busy) begin
        frame_map.note_request('{opcode_i, existing_frame_i, query_frame_i, is_kernel_i,
                                 is_writeable_i});
      end
      if (cfg_valid_i && cfg_ready_o) begin
        frame_map.set_limit(cfg_frames_in_use_i);
      end
    end
  end

  // Presents one request and returns at the edge that accepts it. Start is left high,
  // so that a following request can go out back to back; whoever comes next either
  // drives new fields or lowers start in this same time step.
  task automatic drive_request(input frame_req_t req);
    start            <= 1'b1;
    opcode_i         <= req.opcode;
    existing_frame_i <= req.existing;
    query_frame_i    <= req.query;
    is_kernel_i      <= req.kernel;
    is_writeable_i   <= req.writeable;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds the sender back until every outstanding reply has arrived. A request accepted
  // at the edge just passed may not have been noted yet, so it waits for an edge first.
  task automatic wait_for_replies();
    start <= 1'b0;
    @(posedge clk_i);
    while (frame_map.outstanding() != 0) @(posedge clk_i);
  endtask

  // The count register is only ever written while the allocator is idle.
  task automatic write_frame_limit(input logic [CountW-1:0] value);
    wait_for_replies();
    cfg_valid_i         <= 1'b1;
    cfg_frames_in_use_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // A random request. Allocations mostly come from empty page entries so that the map
  // fills up, and frees mostly name frames near the managed range so that they land
  // on frames that are really in use. The rest covers the whole of every field.
  function automatic frame_req_t random_request(input int unsigned alloc_pct,
                                                input int unsigned span);
    frame_req_t  req;
    int unsigned roll;
    roll          = $urandom_range(99);
    req.kernel    = 1'($urandom_range(1));
    req.writeable = 1'($urandom_range(1));
    req.query     = FrameW'($urandom());
    req.existing  = FrameW'($urandom());
    if (roll < alloc_pct) begin
      req.opcode = OP_ALLOC;
      if ($urandom_range(9) != 0) req.existing = '0;
    end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
      req.opcode = OP_FREE;
      if ($urandom_range(7) != 0) req.existing = FrameW'($urandom_range(span, 1));
      else if ($urandom_range(7) == 0) req.existing = '0;
    end else if (roll < 97) begin
      req.opcode = OP_TEST;
      if ($urandom_range(3) != 0) req.query = FrameW'($urandom_range(span, 0));
    end else begin
      req.opcode = OpUnused;
    end
    return req;
  endfunction

  initial begin
    int unsigned lim;
    int unsigned span;
    int unsigned alloc_pct;
    bit          quiet;

    // Every input is known from time zero, while reset is held low.
    rst_ni              <= 1'b0;
    start               <= 1'b0;
    opcode_i            <= OP_ALLOC;
    existing_frame_i    <= '0;
    query_frame_i       <= '0;
    is_kernel_i         <= 1'b0;
    is_writeable_i      <= 1'b0;
    cfg_valid_i         <= 1'b0;
    cfg_frames_in_use_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the count left at its reset value. The clearing pass after
    // reset keeps busy high, so the first request simply waits for it. Frame zero is
    // an ordinary frame and goes out first, even though an entry holding it looks empty.
    drive_request('{OP_TEST,  12'h000, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_ALLOC, 12'h000, 12'hFFF, 1'b0, 1'b1});
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b1, 1'b0});
    // Entries that already hold a frame are left alone.
    drive_request('{OP_ALLOC, 12'hFFF, 12'h000, 1'b1, 1'b1});
    drive_request('{OP_ALLOC, 12'h001, 12'hFFF, 1'b0, 1'b1});
    drive_request('{OP_TEST,  12'hFFF, 12'h001, 1'b1, 1'b1});
    drive_request('{OP_TEST,  12'h000, 12'hFFF, 1'b0, 1'b0});
    drive_request('{OP_TEST,  12'h000, 12'h000, 1'b0, 1'b0});
    // Freeing an empty entry does nothing; freeing a frame already free still succeeds.
    drive_request('{OP_FREE,  12'h000, 12'h000, 1'b1, 1'b1});
    drive_request('{OP_FREE,  12'h001, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_FREE,  12'h001, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_FREE,  12'hFFF, 12'hFFF, 1'b1, 1'b0});
    // The unused opcode changes nothing and echoes the held frame.
    drive_request('{OpUnused, 12'hABC, 12'h555, 1'b1, 1'b1});
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b1, 1'b1});

    // With no frames managed every allocation fails.
    write_frame_limit(13'd0);
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b0, 1'b1});
    drive_request('{OP_TEST,  12'h000, 12'h002, 1'b0, 1'b0});
    drive_request('{OP_FREE,  12'h002, 12'h000, 1'b0, 1'b0});

    // A tiny range that runs full, including a free beyond the count.
    write_frame_limit(13'd3);
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b0, 1'b1});
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b1, 1'b0});
    drive_request('{OP_FREE,  12'h800, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_FREE,  12'h001, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b0, 1'b0});
    drive_request('{OP_ALLOC, 12'h000, 12'h000, 1'b1, 1'b1});

    // Random phases over a spread of frame counts, the extremes among them. The map
    // is not cleared between phases, so low frames gradually fill and later searches
    // have to step over whole used words. Some phases leave out the random gaps.
    phase_limits[9] = $urandom_range(200, 2);
    foreach (phase_limits[p]) begin
      lim = phase_limits[p];
      write_frame_limit(CountW'(lim));
      span      = (lim + 8 > 4095) ? 4095 : lim + 8;
      alloc_pct = $urandom_range(80, 35);
      quiet     = ($urandom_range(2) == 0);
      repeat (42) begin
        drive_request(random_request(alloc_pct, span));
        if ($urandom_range(29) == 0) wait_for_replies();
        else if (!quiet) idle_for(gap_cycles());
      end
    end

    wait_for_replies();
    repeat (8) @(posedge clk_i);
    if (frame_map.mismatches == 0 && frame_map.outstanding() == 0) begin
      $display("frame_bitmap_allocator_unit_test OK");
    end else begin
      $display("frame_bitmap_allocator_unit_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every search stepping
  // over the whole map and every gap at its longest.
  initial begin
    #10_000_000;
    $display("frame_bitmap_allocator_unit_test NOT OK");
    $finish;
  end

endmodule
